// File: src/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants of the scanline span fill block.
// ----------------------------------------------------------------------------
`default_nettype none
package psf_pkg;

	localparam int XW = 12;
	localparam int YW = 9;
	localparam logic signed [XW-1:0] X_EMPTY_LEFT  = 12'sd2047;
	localparam logic signed [XW-1:0] X_EMPTY_RIGHT = -12'sd2048;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_CROSS2,
		ST_RANGE,
		ST_CLEAR,
		ST_EDGE,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_READ,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // store vertex on input beat
		logic close;       // latch close bookkeeping
		logic cross_a;     // form cross products
		logic cross_b;     // compare cross
		logic range_step;  // scan one corner for y range
		logic range_init;
		logic clear_step;  // clear one row
		logic edge_setup;  // load edge endpoints, start divider
		logic div_step;    // one quotient bit
		logic walk_rd;     // read row bounds
		logic walk_wr;     // merge and write back, step x
		logic horiz_next;  // second endpoint of horizontal edge
		logic finish;      // publish spans after the last edge
		logic read_rd;     // read span row
		logic read_out;    // emit result
		logic read_empty;  // emit empty answer
	} psf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic few;         // fewer than three corners
		logic cull;        // cross product positive
		logic range_done;
		logic clear_done;
		logic div_done;
		logic edge_horiz;
		logic horiz_second;
		logic walk_done;
		logic edges_done;
		logic spans_ready;
	} psf_sts_t;

endpackage
`default_nettype wire

// File: src/psf_ram.sv
// ----------------------------------------------------------------------------
// psf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module psf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 512
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// File: src/psf_datapath.sv
// ----------------------------------------------------------------------------
// psf_datapath
// Corner store, cross product, edge divider, edge walk and row bound RAMs.
// ----------------------------------------------------------------------------
`default_nettype none
module psf_datapath #(
	parameter int MAX_CORNERS = 8,
	parameter int ROWS = 512,
	parameter int FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  psf_pkg::psf_cmd_t    cmd,
	output psf_pkg::psf_sts_t          sts,
	input  wire                        last_vertex,
	input  wire  signed [11:0]         vertex_x,
	input  wire  [8:0]                 vertex_y,
	output logic [8:0]                 span_row,
	output logic signed [11:0]         span_left,
	output logic signed [11:0]         span_right,
	output logic                       span_valid,
	output logic                       last_span,
	output logic                       culled
);
	import psf_pkg::*;

	localparam int CW = $clog2(MAX_CORNERS + 1);
	localparam int CIW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
	localparam int RAW = $clog2(ROWS);
	// quotient magnitude: |dx| < 2^12, so |dx<<F| < 2^(12+F)
	localparam int QW = XW + FRAC_BITS + 1;
	localparam int NW = QW;               // dividend magnitude width
	localparam int DBW = $clog2(QW + 1);

	// corner store, fixed-index registers
	logic signed [XW-1:0] cx_q [MAX_CORNERS];
	logic [YW-1:0]        cy_q [MAX_CORNERS];
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        n_q;

	// span bookkeeping
	logic [YW-1:0] ymin_q, ymax_q, bot_q;
	logic [YW:0]   read_row_q;
	logic          ready_q, culled_q;

	// general counters
	logic [CW-1:0] idx_q;
	logic [YW:0]   row_q;

	// cross product terms
	logic signed [2*XW+1:0] p1_q, p2_q;

	// edge walk
	logic signed [XW-1:0] xa_q, xb_q;
	logic [YW-1:0]        ya_q, yb_q;
	logic                 horiz_q, hsec_q;
	logic signed [QW+XW:0] cur_q;
	logic signed [QW:0]   step_q;

	// divider
	logic [NW-1:0] dnum_q, dquo_q;
	logic [NW:0]   drem_q;
	logic [YW-1:0] dden_q;
	logic          dneg_q;
	logic [DBW-1:0] dcnt_q;

	// row RAMs
	logic                 ram_we;
	logic [RAW-1:0]       ram_addr;
	logic [XW-1:0]        wl, wr_d, rl, rr;

	// corner load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
		end else if (cmd.load) begin
			if (count_q < CW'(MAX_CORNERS)) begin
				cx_q[count_q[CIW-1:0]] <= vertex_x;
				cy_q[count_q[CIW-1:0]] <= vertex_y;
			end
			if (last_vertex) begin
				n_q     <= (count_q < CW'(MAX_CORNERS)) ? count_q + 1'b1 : count_q;
				count_q <= '0;
			end else if (count_q < CW'(MAX_CORNERS)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// cross products, one multiply each then registered
	logic signed [XW:0] ex1, ex2;
	logic signed [YW:0] ey1, ey2;
	assign ex1 = (XW+1)'(cx_q[1]) - (XW+1)'(cx_q[0]);
	assign ex2 = (XW+1)'(cx_q[2]) - (XW+1)'(cx_q[1]);
	assign ey1 = $signed({1'b0, cy_q[1]}) - $signed({1'b0, cy_q[0]});
	assign ey2 = $signed({1'b0, cy_q[2]}) - $signed({1'b0, cy_q[1]});

	always_ff @(posedge clk) begin
		if (cmd.cross_a) begin
			p1_q <= (2*XW+2)'(ex1) * (2*XW+2)'(ey2);
			p2_q <= (2*XW+2)'(ey1) * (2*XW+2)'(ex2);
		end
	end

	// edge endpoints
	logic [CW-1:0] jdx;
	assign jdx = (idx_q + 1'b1 < n_q) ? idx_q + 1'b1 : '0;

	logic signed [XW-1:0] ex_a, ex_b;
	logic [YW-1:0]        ey_a, ey_b;
	assign ex_a = cx_q[idx_q[CIW-1:0]];
	assign ey_a = cy_q[idx_q[CIW-1:0]];
	assign ex_b = cx_q[jdx[CIW-1:0]];
	assign ey_b = cy_q[jdx[CIW-1:0]];

	logic signed [XW:0] dx_w;
	assign dx_w = (XW+1)'(xb_q) - (XW+1)'(xa_q);

	// x truncated toward zero
	logic signed [QW+XW:0] cur_adj;
	logic signed [XW-1:0]  cur_x;
	assign cur_adj = cur_q[QW+XW] ? cur_q + (QW+XW+1)'((1 << FRAC_BITS) - 1) : cur_q;
	assign cur_x = XW'(cur_adj >>> FRAC_BITS);

	// merge x into row bounds
	logic signed [XW-1:0] mx;
	assign mx = horiz_q ? (hsec_q ? xb_q : xa_q) : cur_x;

	logic [YW:0] wrow;
	assign wrow = horiz_q ? {1'b0, ya_q} : row_q;

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q    <= 1'b0;
			culled_q   <= 1'b0;
			bot_q      <= '0;
			read_row_q <= '0;
			idx_q      <= '0;
			row_q      <= '0;
			hsec_q     <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			if (cmd.close) begin
				ready_q  <= 1'b0;
				culled_q <= 1'b0;
			end
			if (cmd.cross_b && p1_q > p2_q) culled_q <= 1'b1;
			if (cmd.range_init) begin
				idx_q  <= '0;
				ymin_q <= cy_q[0];
				ymax_q <= cy_q[0];
			end
			if (cmd.range_step) begin
				if (ey_a < ymin_q) ymin_q <= ey_a;
				if (ey_a > ymax_q) ymax_q <= ey_a;
				idx_q <= idx_q + 1'b1;
				if (idx_q + 1'b1 >= n_q) row_q <= {1'b0, (ey_a < ymin_q) ? ey_a : ymin_q};
			end
			if (cmd.clear_step) begin
				row_q <= row_q + 1'b1;
				idx_q <= '0;
			end
			if (cmd.edge_setup) begin
				hsec_q <= 1'b0;
				if (ey_a <= ey_b) begin
					xa_q <= ex_a; ya_q <= ey_a; xb_q <= ex_b; yb_q <= ey_b;
				end else begin
					xa_q <= ex_b; ya_q <= ey_b; xb_q <= ex_a; yb_q <= ey_a;
				end
				horiz_q <= (ey_a == ey_b);
				dcnt_q  <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == '0) begin
					dneg_q <= dx_w[XW];
					dnum_q <= NW'(dx_w[XW] ? -dx_w : dx_w) << FRAC_BITS;
					dden_q <= yb_q - ya_q;
					drem_q <= '0;
					dquo_q <= '0;
					row_q  <= {1'b0, ya_q};
					cur_q  <= (QW+XW+1)'(xa_q) <<< FRAC_BITS;
				end else begin
					logic [NW:0] t;
					t = {drem_q[NW-1:0], dnum_q[NW-1]};
					dnum_q <= dnum_q << 1;
					if (t >= (NW+1)'(dden_q)) begin
						drem_q <= t - (NW+1)'(dden_q);
						dquo_q <= {dquo_q[NW-2:0], 1'b1};
					end else begin
						drem_q <= t;
						dquo_q <= {dquo_q[NW-2:0], 1'b0};
					end
				end
			end
			if (cmd.walk_wr) begin
				if (horiz_q) begin
					hsec_q <= ~hsec_q;
				end else begin
					row_q <= row_q + 1'b1;
					cur_q <= cur_q + (QW+XW+1)'(step_q);
				end
			end
			if (cmd.horiz_next || (cmd.walk_wr && sts.walk_done && !horiz_q)
			    || (cmd.walk_wr && horiz_q && hsec_q))
				idx_q <= idx_q + 1'b1;
			if (cmd.finish) begin
				bot_q      <= ymax_q;
				read_row_q <= {1'b0, ymin_q};
				ready_q    <= 1'b1;
			end
			if (cmd.read_rd) begin
				if (read_row_q >= {1'b0, bot_q}) ready_q <= 1'b0;
				else read_row_q <= read_row_q + 1'b1;
			end
		end
	end

	// signed step from quotient magnitude
	always_comb begin
		step_q = dneg_q ? -$signed({1'b0, dquo_q}) : $signed({1'b0, dquo_q});
	end

	// RAM port control
	logic in_rows;
	always_comb begin
		ram_we   = 1'b0;
		wl       = X_EMPTY_LEFT;
		wr_d     = X_EMPTY_RIGHT;
		ram_addr = RAW'(row_q);
		in_rows  = (row_q < (YW+1)'(ROWS));
		if (cmd.clear_step) begin
			ram_we = in_rows;
		end else if (cmd.walk_rd || cmd.walk_wr) begin
			ram_addr = RAW'(wrow);
			in_rows  = (wrow < (YW+1)'(ROWS));
			if (cmd.walk_wr) begin
				ram_we = in_rows;
				wl   = (mx < $signed(rl)) ? mx : rl;
				wr_d = (mx > $signed(rr)) ? mx : rr;
			end
		end else if (cmd.read_rd) begin
			ram_addr = RAW'(read_row_q);
		end
	end

	psf_ram #(.WIDTH(XW), .DEPTH(ROWS)) u_left (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wl), .rdata(rl));
	psf_ram #(.WIDTH(XW), .DEPTH(ROWS)) u_right (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wr_d), .rdata(rr));

	// result beat
	logic [YW:0] out_row_q;
	logic        out_last_q;
	always_ff @(posedge clk) begin
		if (cmd.read_rd) begin
			out_row_q  <= read_row_q;
			out_last_q <= (read_row_q >= {1'b0, bot_q});
		end
	end

	always_comb begin
		span_row   = '0;
		span_left  = '0;
		span_right = '0;
		span_valid = 1'b0;
		last_span  = 1'b1;
		culled     = culled_q;
		if (cmd.read_out && !cmd.read_empty) begin
			span_row   = out_row_q[YW-1:0];
			span_valid = 1'b1;
			last_span  = out_last_q;
			culled     = 1'b0;
			if (out_row_q < (YW+1)'(ROWS)) begin
				span_left  = rl;
				span_right = rr;
			end else begin
				span_left  = X_EMPTY_LEFT;
				span_right = X_EMPTY_RIGHT;
			end
		end
	end

	// status
	always_comb begin
		sts.few          = (n_q < CW'(3));
		sts.cull         = (p1_q > p2_q);
		sts.range_done   = (idx_q + 1'b1 >= n_q);
		sts.clear_done   = (row_q >= {1'b0, ymax_q});
		sts.div_done     = (dcnt_q == DBW'(NW));
		sts.edge_horiz   = horiz_q;
		sts.horiz_second = hsec_q;
		sts.walk_done    = (row_q >= {1'b0, yb_q});
		sts.edges_done   = (idx_q >= n_q);
		sts.spans_ready  = ready_q;
	end

`ifndef SYNTHESIS
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dcnt_q <= DBW'(NW))
		else $error("divider ran past its bit count");
	a_we_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cmd.clear_step || cmd.walk_wr))
		else $error("row write outside clear or walk");
	a_ready_close: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> !ready_q)
		else $error("spans survived a close");
`endif
endmodule
`default_nettype wire

// File: src/psf_ctrl.sv
// ----------------------------------------------------------------------------
// psf_ctrl
// Sequencer for load, close (cull, clear, edge walk) and span read.
// ----------------------------------------------------------------------------
`default_nettype none
module psf_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire                     func,
	input  wire                     last_vertex,
	input  wire  psf_pkg::psf_sts_t sts,
	output psf_pkg::psf_cmd_t       cmd,
	output logic                    busy,
	output logic                    strobe
);
	import psf_pkg::*;

	state_t state_q, state_d;
	logic   empty_q, empty_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			empty_q <= empty_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		empty_d = empty_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_READ) begin
						empty_d = !sts.spans_ready;
						state_d = sts.spans_ready ? ST_READ : ST_OUT;
					end else if (last_vertex) begin
						state_d = ST_CROSS;
					end
				end
			end
			ST_CROSS:   state_d = sts.few ? ST_IDLE : ST_CROSS2;
			ST_CROSS2:  state_d = sts.cull ? ST_IDLE : ST_RANGE;
			ST_RANGE:   state_d = sts.range_done ? ST_CLEAR : ST_RANGE;
			ST_CLEAR:   state_d = sts.clear_done ? ST_EDGE : ST_CLEAR;
			ST_EDGE:    state_d = sts.edges_done ? ST_IDLE : ST_DIV;
			ST_DIV:     state_d = (sts.edge_horiz || sts.div_done) ? ST_WALK_RD : ST_DIV;
			ST_WALK_RD: state_d = ST_WALK_WR;
			ST_WALK_WR: begin
				if (sts.edge_horiz) state_d = sts.horiz_second ? ST_EDGE : ST_WALK_RD;
				else state_d = sts.walk_done ? ST_EDGE : ST_WALK_RD;
			end
			ST_READ:    state_d = ST_OUT;
			ST_OUT:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		strobe = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = start && (func == FUNC_LOAD);
				cmd.close = start && (func == FUNC_LOAD) && last_vertex;
			end
			ST_CROSS:   cmd.cross_a = 1'b1;
			ST_CROSS2: begin
				cmd.cross_b    = 1'b1;
				cmd.range_init = 1'b1;
			end
			ST_RANGE:   cmd.range_step = 1'b1;
			ST_CLEAR:   cmd.clear_step = 1'b1;
			ST_EDGE: begin
				cmd.edge_setup = !sts.edges_done;
				cmd.finish     = sts.edges_done;
			end
			ST_DIV:     cmd.div_step = 1'b1;
			ST_WALK_RD: cmd.walk_rd = 1'b1;
			ST_WALK_WR: cmd.walk_wr = 1'b1;
			ST_READ:    cmd.read_rd = 1'b1;
			ST_OUT: begin
				cmd.read_out   = 1'b1;
				cmd.read_empty = empty_q;
				strobe         = 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_strobe_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> state_q == ST_OUT)
		else $error("strobe outside output state");
	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_OUT))
		else $error("span read did not reach output");
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy)
		else $error("busy while idle");
`endif
endmodule
`default_nettype wire

// File: src/polygon_scanline_span_fill.sv
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill
// Convex polygon scan conversion into per-row spans.
// ----------------------------------------------------------------------------
// A load that does not close the polygon is taken while busy stays low. A
// closing load raises busy for the cull test, a scan of the corners for the
// row range, a clear of the covered rows (one row a cycle), then per edge a
// setup state, a divide (cut short for a horizontal edge) and a row bound RAM
// read-modify-write for each row walked (for both endpoints of a horizontal
// edge), and a last step to publish the spans. A read holds busy through its
// read and output states and its result appears in the output state with
// strobe; a read with no span left goes straight to the output state with the
// strobe. Results cannot be held off, so capture them on strobe.
`default_nettype none
module polygon_scanline_span_fill #(
	parameter int MAX_CORNERS = 8,
	parameter int ROWS = 512,
	parameter int FRAC_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               func,
	input  wire signed [11:0] vertex_x,
	input  wire        [8:0]  vertex_y,
	input  wire               last_vertex,
	output logic              strobe,
	output logic       [8:0]  span_row,
	output logic signed [11:0] span_left,
	output logic signed [11:0] span_right,
	output logic              span_valid,
	output logic              last_span,
	output logic              culled
);
	import psf_pkg::*;

	psf_cmd_t cmd;
	psf_sts_t sts;

	psf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.last_vertex(last_vertex), .sts(sts), .cmd(cmd), .busy(busy), .strobe(strobe));

	psf_datapath #(.MAX_CORNERS(MAX_CORNERS), .ROWS(ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .last_vertex(last_vertex),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .span_row(span_row),
		.span_left(span_left), .span_right(span_right), .span_valid(span_valid),
		.last_span(last_span), .culled(culled));
endmodule
`default_nettype wire
